>>> hw/rtl/dsd_pkg.sv
// dsd_pkg: shared types, register indexes and reset values of the double shake detector
// no dependencies; used by every module under hw/rtl
package dsd_pkg;

   localparam int SAMPLE_BITS_DEFAULT = 16;
   localparam int TIME_BITS_DEFAULT   = 32;

   localparam int LEVEL_W  = 32;
   localparam int MS_W     = 16;
   localparam int CSR_W    = 32;
   localparam int CSR_IDX_W = 3;

   // reset thresholds: (1.45 g * 8192)^2 and (1.10 g * 8192)^2, rounded
   localparam logic [LEVEL_W-1:0] SPIKE_LEVEL_RESET = 32'd141096387;
   localparam logic [LEVEL_W-1:0] REARM_LEVEL_RESET = 32'd81201725;
   localparam logic [MS_W-1:0]    COOLDOWN_RESET    = 16'd120;
   localparam logic [MS_W-1:0]    WINDOW_MIN_RESET  = 16'd200;
   localparam logic [MS_W-1:0]    WINDOW_MAX_RESET  = 16'd900;

   typedef enum logic [0:0] {
      OP_SAMPLE  = 1'b0,
      OP_CONSUME = 1'b1
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SPIKE_LEVEL = 3'd0,
      CSR_REARM_LEVEL = 3'd1,
      CSR_COOLDOWN    = 3'd2,
      CSR_WINDOW_MIN  = 3'd3,
      CSR_WINDOW_MAX  = 3'd4
   } csr_index_type;

   typedef struct packed {
      op_type             op;
      logic [31:0]        sample_time_ms;
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_z;
   } req_type;

   typedef struct packed {
      logic spike;
      logic pair_found;
      logic taken;
      logic is_armed;
   } rsp_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] spike_level_sq;
      logic [LEVEL_W-1:0] rearm_level_sq;
      logic [MS_W-1:0]    cooldown_ms;
      logic [MS_W-1:0]    window_min_ms;
      logic [MS_W-1:0]    window_max_ms;
   } cfg_type;

endpackage

>>> hw/rtl/dsd_csr.sv
// dsd_csr: configuration registers of the double shake detector
// depends on dsd_pkg (cfg_type, register indexes, reset values)
module dsd_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_en,
   input  logic [dsd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [dsd_pkg::CSR_W-1:0]     csr_wdata,
   output dsd_pkg::cfg_type              cfg
);

   dsd_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.spike_level_sq <= dsd_pkg::SPIKE_LEVEL_RESET;
         cfg_ff.rearm_level_sq <= dsd_pkg::REARM_LEVEL_RESET;
         cfg_ff.cooldown_ms    <= dsd_pkg::COOLDOWN_RESET;
         cfg_ff.window_min_ms  <= dsd_pkg::WINDOW_MIN_RESET;
         cfg_ff.window_max_ms  <= dsd_pkg::WINDOW_MAX_RESET;
      end else if (csr_write_en) begin
         case (dsd_pkg::csr_index_type'(csr_index))
            dsd_pkg::CSR_SPIKE_LEVEL: begin
               cfg_ff.spike_level_sq <= csr_wdata[dsd_pkg::LEVEL_W-1:0];
            end
            dsd_pkg::CSR_REARM_LEVEL: begin
               cfg_ff.rearm_level_sq <= csr_wdata[dsd_pkg::LEVEL_W-1:0];
            end
            dsd_pkg::CSR_COOLDOWN: begin
               cfg_ff.cooldown_ms <= csr_wdata[dsd_pkg::MS_W-1:0];
            end
            dsd_pkg::CSR_WINDOW_MIN: begin
               cfg_ff.window_min_ms <= csr_wdata[dsd_pkg::MS_W-1:0];
            end
            dsd_pkg::CSR_WINDOW_MAX: begin
               cfg_ff.window_max_ms <= csr_wdata[dsd_pkg::MS_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> hw/rtl/dsd_mag.sv
// dsd_mag: input register and squared magnitude register of the double shake detector
// depends on dsd_pkg (req_type, op_type)
module dsd_mag #(
   parameter int SAMPLE_BITS = dsd_pkg::SAMPLE_BITS_DEFAULT,
   parameter int TIME_BITS   = dsd_pkg::TIME_BITS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  dsd_pkg::req_type           in_data,
   output logic                       out_valid,
   input  logic                       out_ready,
   output dsd_pkg::op_type            out_op,
   output logic [TIME_BITS-1:0]       out_time,
   output logic [2*SAMPLE_BITS-1:0]   out_mag
);

   localparam int MAG_BITS = 2 * SAMPLE_BITS;

   // capture stage
   logic                          s1_valid_ff;
   dsd_pkg::op_type               s1_op_ff;
   logic [TIME_BITS-1:0]          s1_time_ff;
   logic signed [SAMPLE_BITS-1:0] s1_x_ff, s1_y_ff, s1_z_ff;

   // magnitude stage
   logic                  s2_valid_ff;
   dsd_pkg::op_type       s2_op_ff;
   logic [TIME_BITS-1:0]  s2_time_ff;
   logic [MAG_BITS-1:0]   s2_mag_ff;

   logic s1_ready, s2_ready;
   logic signed [MAG_BITS-1:0] sq_x, sq_y, sq_z;
   logic [MAG_BITS-1:0] s2_mag_in;

   assign s2_ready = !s2_valid_ff || out_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   // three squares are non-negative and their sum stays below 2^MAG_BITS
   assign sq_x = s1_x_ff * s1_x_ff;
   assign sq_y = s1_y_ff * s1_y_ff;
   assign sq_z = s1_z_ff * s1_z_ff;
   assign s2_mag_in = MAG_BITS'($unsigned(sq_x)) + MAG_BITS'($unsigned(sq_y))
                      + MAG_BITS'($unsigned(sq_z));

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= in_valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && s1_ready) begin
         s1_op_ff   <= in_data.op;
         s1_time_ff <= in_data.sample_time_ms[TIME_BITS-1:0];
         s1_x_ff    <= in_data.accel_x[SAMPLE_BITS-1:0];
         s1_y_ff    <= in_data.accel_y[SAMPLE_BITS-1:0];
         s1_z_ff    <= in_data.accel_z[SAMPLE_BITS-1:0];
      end
      if (s1_valid_ff && s2_ready) begin
         s2_op_ff   <= s1_op_ff;
         s2_time_ff <= s1_time_ff;
         s2_mag_ff  <= s2_mag_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_op    = s2_op_ff;
   assign out_time  = s2_time_ff;
   assign out_mag   = s2_mag_ff;

endmodule

>>> hw/rtl/dsd_core.sv
// dsd_core: spike decision, detector state and result register of the double shake detector
// depends on dsd_pkg (cfg_type, rsp_type, op_type)
module dsd_core #(
   parameter int SAMPLE_BITS = dsd_pkg::SAMPLE_BITS_DEFAULT,
   parameter int TIME_BITS   = dsd_pkg::TIME_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  dsd_pkg::cfg_type         cfg,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  dsd_pkg::op_type          in_op,
   input  logic [TIME_BITS-1:0]     in_time,
   input  logic [2*SAMPLE_BITS-1:0] in_mag,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output dsd_pkg::rsp_type         rsp_data
);

   localparam int MAG_BITS = 2 * SAMPLE_BITS;
   localparam int CMP_BITS = (MAG_BITS > dsd_pkg::LEVEL_W) ? MAG_BITS : dsd_pkg::LEVEL_W;

   logic                 armed_ff, armed_in;
   logic [TIME_BITS-1:0] last_ff, last_in;
   logic                 latch_ff, latch_in;
   logic                 rsp_valid_ff;
   dsd_pkg::rsp_type     rsp_data_ff, rsp_data_in;

   logic                 fire;
   logic [TIME_BITS-1:0] since;
   logic                 above, below, past_cooldown, in_window, have_prev, hit;

   assign in_ready = !rsp_valid_ff || rsp_ready;
   assign fire     = in_valid && in_ready;

   assign since         = in_time - last_ff;
   assign above         = CMP_BITS'(in_mag) > CMP_BITS'(cfg.spike_level_sq);
   assign below         = CMP_BITS'(in_mag) < CMP_BITS'(cfg.rearm_level_sq);
   assign past_cooldown = since > TIME_BITS'(cfg.cooldown_ms);
   assign in_window     = (since >= TIME_BITS'(cfg.window_min_ms))
                          && (since <= TIME_BITS'(cfg.window_max_ms));
   // a stored time of zero means no spike on record
   assign have_prev     = last_ff != '0;
   assign hit           = armed_ff && above && past_cooldown;

   always_comb begin
      armed_in    = armed_ff;
      last_in     = last_ff;
      latch_in    = latch_ff;
      rsp_data_in = '0;
      if (in_op == dsd_pkg::OP_CONSUME) begin
         rsp_data_in.taken = latch_ff;
         latch_in          = 1'b0;
      end else if (hit) begin
         rsp_data_in.spike = 1'b1;
         armed_in          = 1'b0;
         last_in           = in_time;
         if (have_prev && in_window) begin
            rsp_data_in.pair_found = 1'b1;
            latch_in               = 1'b1;
            last_in                = '0;
         end
      end else if (!armed_ff && below) begin
         armed_in = 1'b1;
      end
      rsp_data_in.is_armed = armed_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff     <= 1'b1;
         last_ff      <= '0;
         latch_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (fire) begin
            armed_ff <= armed_in;
            last_ff  <= last_in;
            latch_ff <= latch_in;
         end
         if (in_ready) begin
            rsp_valid_ff <= in_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_pair_is_spike: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.pair_found |-> rsp_data_ff.spike)
      else $error("pair reported without a spike");

   a_spike_disarms: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.spike |-> !rsp_data_ff.is_armed && !armed_ff)
      else $error("detector still armed after a spike");

   a_pair_sets_latch: assert property (@(posedge clock) disable iff (reset)
      fire && rsp_data_in.pair_found |=> latch_ff && (last_ff == '0))
      else $error("pair did not set the latch or clear the spike time");

   a_consume_clears: assert property (@(posedge clock) disable iff (reset)
      fire && (in_op == dsd_pkg::OP_CONSUME) |=> !latch_ff && !rsp_data_ff.spike
      && !rsp_data_ff.pair_found)
      else $error("consume left the latch set or reported a spike");

endmodule

>>> hw/rtl/double_shake_detector.sv
// double_shake_detector: top level of the accelerometer double shake detector
// depends on dsd_pkg, dsd_csr, dsd_mag and dsd_core
//
// usage
//  - req channel (valid/ready): one beat is either an accelerometer sample
//    (op = OP_SAMPLE, millisecond timestamp and raw x/y/z at 8192 lsb per g)
//    or a consume request (op = OP_CONSUME) that reads and clears the latch
//  - rsp channel (valid/ready): exactly one beat per req beat, in order,
//    carrying spike, pair_found, taken and the armed state after the item
//  - csr port: plain write port, csr_write_en with csr_index and csr_wdata,
//    taken at the clock edge; unknown indexes are ignored; write only while idle
//  - pipeline: a req beat passes the input register, the squared magnitude
//    register and the result register before rsp_valid rises
//  - throughput: one beat per cycle if not stalled; the three 16x16 squares
//    sit in their own stage and the threshold, cooldown and window compares
//    plus the state update fit in the stage that loads the result register
//  - stall: when rsp_ready is low the result register holds; beats already
//    accepted move up into empty stages, and req_ready drops only once every
//    stage holds a beat
//  - reset (synchronous, active high): thresholds and timings back to their
//    defaults, detector armed, no spike on record, latch clear, pipeline empty
module double_shake_detector #(
   parameter int SAMPLE_BITS = dsd_pkg::SAMPLE_BITS_DEFAULT,
   parameter int TIME_BITS   = dsd_pkg::TIME_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   // request beats
   input  logic                          req_valid,
   output logic                          req_ready,
   input  dsd_pkg::req_type              req_data,
   // result beats
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output dsd_pkg::rsp_type              rsp_data,
   // configuration writes
   input  logic                          csr_write_en,
   input  logic [dsd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [dsd_pkg::CSR_W-1:0]     csr_wdata
);

   dsd_pkg::cfg_type             cfg;
   logic                         mag_valid, mag_ready;
   dsd_pkg::op_type              mag_op;
   logic [TIME_BITS-1:0]         mag_time;
   logic [2*SAMPLE_BITS-1:0]     mag_sq;

   // threshold and timing registers
   dsd_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   // input capture and squared magnitude, no square root needed
   dsd_mag #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .TIME_BITS   (TIME_BITS)
   ) u_mag (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (mag_valid),
      .out_ready (mag_ready),
      .out_op    (mag_op),
      .out_time  (mag_time),
      .out_mag   (mag_sq)
   );

   // arm/spike/pair decision, detector state and result register
   dsd_core #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .TIME_BITS   (TIME_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (mag_valid),
      .in_ready  (mag_ready),
      .in_op     (mag_op),
      .in_time   (mag_time),
      .in_mag    (mag_sq),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

>>> sim/double_shake_detector_tb.sv
// double_shake_detector_tb: self-checking bench for the double shake detector, with its own
// cycle-free predictor of spikes, pairs, latch and armed state; drives req/rsp/csr ports
// depends on dsd_pkg and the rtl under hw/rtl, nothing else
module double_shake_detector_tb;
   import dsd_pkg::*;

   // three pipeline stages from req acceptance to rsp_valid
   localparam int LATENCY      = 3;
   // cycles without any beat moving before the run is called hung
   localparam int STALL_LIMIT  = 2000;
   localparam int REPORT_LIMIT = 10;
   // largest squared magnitude the fields allow: 3 * 32768^2
   localparam logic [LEVEL_W-1:0] LEVEL_TOP = 32'd3221225472;
   localparam logic [MS_W-1:0]    MS_TOP    = 16'hFFFF;

   logic                 clock;
   logic                 reset        = 1'b1;
   logic                 req_valid    = 1'b0;
   logic                 req_ready;
   req_type              req_data     = '0;
   logic                 rsp_valid;
   logic                 rsp_ready    = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index    = '0;
   logic [CSR_W-1:0]     csr_wdata    = '0;

   double_shake_detector u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // shadow of the detector: thresholds plus the three pieces of state
   cfg_type     cfg_shadow;
   logic        armed_shadow;
   logic [31:0] spike_stamp_shadow;
   logic        latch_shadow;

   // results still owed by the block, oldest first
   rsp_type     owed_results[$];

   int          fail_count     = 0;
   int          results_seen   = 0;
   int          quiet_cycles   = 0;
   int          beats_sent     = 0;
   int          send_idle_pct  = 0;
   int          recv_stall_pct = 0;
   // running millisecond timestamp for generated samples
   logic [31:0] stamp_ms       = 32'd10000;

   // --------------------------------------------------------------------------
   // predictor
   // --------------------------------------------------------------------------

   // works out the result of one accepted beat and moves the shadow state on
   function automatic rsp_type predict_shake(req_type beat);
      rsp_type     res;
      int          sx, sy, sz;
      logic [33:0] mag_sq;
      logic [31:0] since_ms;
      res = '0;
      if (beat.op == OP_CONSUME) begin
         // hand back the latch and clear it, armed state untouched
         res.taken    = latch_shadow;
         latch_shadow = 1'b0;
      end else begin
         sx       = beat.accel_x;
         sy       = beat.accel_y;
         sz       = beat.accel_z;
         // exact sum of squares, at most 3 * 2^30 so 34 bits is plenty
         mag_sq   = 34'(sx * sx) + 34'(sy * sy) + 34'(sz * sz);
         // wraps mod 2^32; with nothing on record this is just the timestamp
         since_ms = beat.sample_time_ms - spike_stamp_shadow;
         if (armed_shadow && mag_sq > 34'(cfg_shadow.spike_level_sq) &&
             since_ms > 32'(cfg_shadow.cooldown_ms)) begin
            res.spike    = 1'b1;
            armed_shadow = 1'b0;
            // a zero record means no earlier spike, so no pair can form
            if (spike_stamp_shadow != '0 && since_ms >= 32'(cfg_shadow.window_min_ms) &&
                since_ms <= 32'(cfg_shadow.window_max_ms)) begin
               latch_shadow       = 1'b1;
               spike_stamp_shadow = '0;
               res.pair_found     = 1'b1;
            end else begin
               // a spike at time zero lands here too and reads as none
               spike_stamp_shadow = beat.sample_time_ms;
            end
         end else if (!armed_shadow && mag_sq < 34'(cfg_shadow.rearm_level_sq)) begin
            armed_shadow = 1'b1;
         end
      end
      res.is_armed = armed_shadow;
      return res;
   endfunction

   // register write as the block should see it; unknown indexes fall through
   function automatic void apply_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] data);
      case (idx)
         CSR_SPIKE_LEVEL: cfg_shadow.spike_level_sq = data[LEVEL_W-1:0];
         CSR_REARM_LEVEL: cfg_shadow.rearm_level_sq = data[LEVEL_W-1:0];
         CSR_COOLDOWN:    cfg_shadow.cooldown_ms    = data[MS_W-1:0];
         CSR_WINDOW_MIN:  cfg_shadow.window_min_ms  = data[MS_W-1:0];
         CSR_WINDOW_MAX:  cfg_shadow.window_max_ms  = data[MS_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic void report_mismatch(string what, rsp_type want, rsp_type got);
      fail_count++;
      if (fail_count <= REPORT_LIMIT)
         $display({"t=%0t result %0d %s: expected spike=%0b pair=%0b taken=%0b armed=%0b,",
                   " got spike=%0b pair=%0b taken=%0b armed=%0b"},
                  $time, results_seen, what, want.spike, want.pair_found, want.taken,
                  want.is_armed, got.spike, got.pair_found, got.taken, got.is_armed);
   endfunction

   // --------------------------------------------------------------------------
   // monitor: one process sees every handshake at the clock edge, so the
   // order of checking, register updates and prediction is fixed
   // --------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         cfg_shadow.spike_level_sq = SPIKE_LEVEL_RESET;
         cfg_shadow.rearm_level_sq = REARM_LEVEL_RESET;
         cfg_shadow.cooldown_ms    = COOLDOWN_RESET;
         cfg_shadow.window_min_ms  = WINDOW_MIN_RESET;
         cfg_shadow.window_max_ms  = WINDOW_MAX_RESET;
         armed_shadow       = 1'b1;
         spike_stamp_shadow = '0;
         latch_shadow       = 1'b0;
         owed_results.delete();
         quiet_cycles  = 0;
      end else begin
         // result side first: it can only belong to an older beat
         if (rsp_valid && rsp_ready) begin
            if (owed_results.size() == 0) begin
               report_mismatch("arrived with nothing expected", '0, rsp_data);
            end else begin
               want = owed_results.pop_front();
               if (rsp_data.spike !== want.spike || rsp_data.pair_found !== want.pair_found ||
                   rsp_data.taken !== want.taken || rsp_data.is_armed !== want.is_armed)
                  report_mismatch("mismatch", want, rsp_data);
            end
            results_seen++;
         end
         if (csr_write_en)
            apply_reg(csr_index, csr_wdata);
         if (req_valid && req_ready)
            owed_results.push_back(predict_shake(req_data));

         // watchdog: anything moving on either channel keeps it quiet
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no beat moved for %0d cycles, %0d results owed",
                     STALL_LIMIT, owed_results.size());
            $display("double_shake_detector_tb: FAIL");
            $finish;
         end
      end
   end

   // receiver back-pressure, redrawn every cycle
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // --------------------------------------------------------------------------
   // beat builders
   // --------------------------------------------------------------------------

   function automatic req_type sample_beat(logic [31:0] t, int x, int y, int z);
      req_type beat;
      beat.op             = OP_SAMPLE;
      beat.sample_time_ms = t;
      beat.accel_x        = 16'(x);
      beat.accel_y        = 16'(y);
      beat.accel_z        = 16'(z);
      return beat;
   endfunction

   // time and axes are junk on a consume and must be ignored
   function automatic req_type consume_beat();
      req_type beat;
      beat.op             = OP_CONSUME;
      beat.sample_time_ms = $urandom();
      beat.accel_x        = 16'($urandom());
      beat.accel_y        = 16'($urandom());
      beat.accel_z        = 16'($urandom());
      return beat;
   endfunction

   // one axis at or above 13000 lsb (about 1.59 g), the other two near zero
   function automatic req_type jolt_beat(logic [31:0] t);
      int v[3];
      int big;
      big = $urandom_range(32767, 13000);
      if ($urandom_range(1)) big = -big;
      for (int a = 0; a < 3; a++) v[a] = int'($urandom_range(1000)) - 500;
      v[$urandom_range(2)] = big;
      return sample_beat(t, v[0], v[1], v[2]);
   endfunction

   // mostly well below the re-arm level, sometimes between the two levels
   function automatic req_type quiet_beat(logic [31:0] t);
      int v[3];
      int mid;
      if ($urandom_range(99) < 80) begin
         for (int a = 0; a < 3; a++) v[a] = int'($urandom_range(6000)) - 3000;
      end else begin
         mid = $urandom_range(11500, 9500);
         if ($urandom_range(1)) mid = -mid;
         for (int a = 0; a < 3; a++) v[a] = int'($urandom_range(1000)) - 500;
         v[$urandom_range(2)] = mid;
      end
      return sample_beat(t, v[0], v[1], v[2]);
   endfunction

   // gap between the two jolts of a gesture, biased to the window and cooldown edges
   function automatic int pick_gap();
      int lo, hi, cool;
      lo   = cfg_shadow.window_min_ms;
      hi   = cfg_shadow.window_max_ms;
      cool = cfg_shadow.cooldown_ms;
      case ($urandom_range(7))
         0:       return lo;
         1:       return hi;
         2:       return (lo > 0) ? lo - 1 : 0;
         3:       return hi + 1;
         4:       return (hi >= lo) ? $urandom_range(hi, lo) : lo;
         5:       return cool;
         6:       return cool + 1;
         default: return $urandom_range(2000);
      endcase
   endfunction

   // --------------------------------------------------------------------------
   // drivers
   // --------------------------------------------------------------------------

   // offers one beat and returns at the edge that accepts it; valid is only
   // dropped when an idle gap is wanted, so back-to-back beats keep it high
   task automatic send_beat(input req_type beat);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_data  <= beat;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      beats_sent++;
   endtask

   // stop offering beats and let every owed result come home; the first edge
   // makes sure the monitor has queued the last accepted beat
   task automatic finish_stream();
      req_valid <= 1'b0;
      @(posedge clock);
      while (owed_results.size() != 0) @(posedge clock);
      repeat (LATENCY + 1) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
   endtask

   // all five registers; junk in the upper half of the 16-bit ones
   task automatic load_config(input logic [LEVEL_W-1:0] spike_sq, input logic [LEVEL_W-1:0] rearm_sq,
                              input logic [MS_W-1:0] cool, input logic [MS_W-1:0] win_lo,
                              input logic [MS_W-1:0] win_hi);
      finish_stream();
      write_reg(CSR_SPIKE_LEVEL, spike_sq);
      write_reg(CSR_REARM_LEVEL, rearm_sq);
      write_reg(CSR_COOLDOWN,    {16'($urandom()), cool});
      write_reg(CSR_WINDOW_MIN,  {16'($urandom()), win_lo});
      write_reg(CSR_WINDOW_MAX,  {16'($urandom()), win_hi});
      csr_write_en <= 1'b0;
      // let the clock run on so the shadow has taken the last write before anyone reads it
      @(posedge clock);
      @(posedge clock);
   endtask

   // jolt, settle, jolt again after a chosen gap, settle, maybe collect the latch
   task automatic play_gesture();
      int          gap, calm_count;
      logic [31:0] first_ms;
      stamp_ms  += 32'(cfg_shadow.cooldown_ms) + 32'($urandom_range(400));
      first_ms   = stamp_ms;
      send_beat(jolt_beat(first_ms));
      calm_count = $urandom_range(3, 1);
      gap        = pick_gap();
      for (int k = 1; k <= calm_count; k++)
         send_beat(quiet_beat(first_ms + 32'(gap * k / (calm_count + 1))));
      stamp_ms   = first_ms + 32'(gap);
      send_beat(jolt_beat(stamp_ms));
      stamp_ms  += 32'($urandom_range(50, 1));
      send_beat(quiet_beat(stamp_ms));
      if ($urandom_range(1))
         send_beat(consume_beat());
   endtask

   // stray consumes, wild timestamps and raw random axes
   task automatic play_noise();
      req_type beat;
      int      pick;
      pick = $urandom_range(99);
      if (pick < 20) begin
         beat = consume_beat();
      end else begin
         if (pick < 35)
            stamp_ms = $urandom();
         else
            stamp_ms += 32'($urandom_range(300));
         if (pick < 70)
            beat = sample_beat(stamp_ms, $urandom(), $urandom(), $urandom());
         else if ($urandom_range(1))
            beat = jolt_beat(stamp_ms);
         else
            beat = quiet_beat(stamp_ms);
      end
      send_beat(beat);
   endtask

   // mostly well-formed gestures with random content, the rest noise
   task automatic run_traffic(input int count);
      int target;
      target = beats_sent + count;
      while (beats_sent < target) begin
         if ($urandom_range(99) < 70)
            play_gesture();
         else
            play_noise();
      end
   endtask

   // --------------------------------------------------------------------------
   // tests
   // --------------------------------------------------------------------------

   // hand-picked walk through the corners, on the reset thresholds
   // (cooldown 120, window 200..900)
   task automatic test_directed_cases();
      send_beat(consume_beat());                                   // empty latch
      send_beat(sample_beat(32'd0, -32768, -32768, -32768));       // early stamp, cooldown blocks
      send_beat(sample_beat(32'd120, 32767, 0, 0));                // exactly on cooldown, no spike
      send_beat(sample_beat(32'd121, 32767, 0, 0));                // first spike, disarms
      send_beat(sample_beat(32'd130, -32768, -32768, -32768));     // disarmed, loud: stays disarmed
      send_beat(sample_beat(32'd200, 0, 0, 0));                    // re-arm
      send_beat(sample_beat(32'd321, 0, -20000, 0));               // gap on window_min: pair
      send_beat(sample_beat(32'd330, -3000, 2000, -1000));         // re-arm
      send_beat(sample_beat(32'd1000, 0, 0, 20000));               // nothing on record: no pair
      send_beat(sample_beat(32'd1010, 100, 100, 100));
      send_beat(sample_beat(32'd1901, 20000, 0, 0));               // one past window_max
      send_beat(sample_beat(32'd1950, 0, 0, 0));
      send_beat(sample_beat(32'd2801, -20000, 0, 0));              // on window_max, latch already set
      send_beat(consume_beat());                                   // latch comes back set
      send_beat(consume_beat());                                   // and is now clear
      send_beat(sample_beat(32'd2850, 0, 0, 0));
      send_beat(sample_beat(32'd3000, 10500, 0, 0));               // armed, between levels: no change
      send_beat(sample_beat(32'd5000, 0, 20000, 0));
      send_beat(sample_beat(32'd5010, 0, 0, 0));
      send_beat(sample_beat(32'd0, 20000, 0, 0));                  // spike at zero reads as none
      send_beat(sample_beat(32'd10, 0, 0, 0));
      send_beat(sample_beat(32'd300, 20000, 0, 0));                // no pair after the zero spike
      send_beat(sample_beat(32'd400, 0, 0, 0));
      send_beat(sample_beat(32'hFFFF_FF00, 32767, 32767, 32767));  // near the top of the stamp
      send_beat(sample_beat(32'hFFFF_FFFF, 0, 0, 0));
      send_beat(sample_beat(32'h0000_01FF, 0, 0, -20000));         // pair across the wrap
   endtask

   // writes to indexes past the last register must change nothing
   task automatic test_unknown_index();
      finish_stream();
      for (int i = int'(CSR_WINDOW_MAX) + 1; i < (1 << CSR_IDX_W); i++)
         write_reg(CSR_IDX_W'(i), $urandom());
      csr_write_en <= 1'b0;
      @(posedge clock);
      @(posedge clock);
      run_traffic(40);
   endtask

   task automatic test_default_levels();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      load_config(SPIKE_LEVEL_RESET, REARM_LEVEL_RESET, COOLDOWN_RESET,
                  WINDOW_MIN_RESET, WINDOW_MAX_RESET);
      run_traffic(300);
   endtask

   // every loud sample spikes while armed, all but the loudest re-arm, any gap of 1 to 65535 ms pairs
   task automatic test_trigger_happy();
      send_idle_pct  = 66;
      recv_stall_pct = 0;
      load_config('0, LEVEL_TOP, '0, '0, MS_TOP);
      run_traffic(300);
   endtask

   // nothing can spike (the top level is not exceeded) and nothing re-arms
   task automatic test_never_trigger();
      send_idle_pct  = 0;
      recv_stall_pct = 66;
      load_config(LEVEL_TOP, '0, MS_TOP, MS_TOP, '0);
      run_traffic(200);
   endtask

   // random plausible thresholds and windows, both sides idling
   task automatic test_random_levels();
      logic [MS_W-1:0] win_lo;
      send_idle_pct  = 29;
      recv_stall_pct = 29;
      repeat (2) begin
         win_lo = MS_W'($urandom_range(500));
         load_config($urandom_range(160000000, 120000000), $urandom_range(90000000, 60000000),
                     MS_W'($urandom_range(300)), win_lo, win_lo + MS_W'($urandom_range(1000)));
         run_traffic(250);
      end
   endtask

   // back on the defaults with stalls on both sides
   task automatic test_defaults_stalled();
      send_idle_pct  = 29;
      recv_stall_pct = 29;
      load_config(SPIKE_LEVEL_RESET, REARM_LEVEL_RESET, COOLDOWN_RESET,
                  WINDOW_MIN_RESET, WINDOW_MAX_RESET);
      run_traffic(250);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_unknown_index();
      test_default_levels();
      test_trigger_happy();
      test_never_trigger();
      test_random_levels();
      test_defaults_stalled();

      finish_stream();
      if (fail_count == 0)
         $display("double_shake_detector_tb: PASS");
      else
         $display("double_shake_detector_tb: FAIL");
      $finish;
   end

endmodule
